// ----- rtl/wsc_pkg.sv -----
package wsc_pkg;

    localparam int MAX_WAYPOINTS_DEF = 256;

    localparam int LATW  = 28;
    localparam int LONW  = 29;
    localparam int HDGW  = 10;
    localparam int SPDW  = 13;
    localparam int CMDW  = 8;
    localparam int IDXW  = 8;
    localparam int ADDRW = 5;
    localparam int DATAW = 32;

    // CORDIC datapath widths
    localparam int CW           = 50;
    localparam int ZW           = 32;
    localparam int CORDIC_STEPS = 16;

    localparam logic signed [CW-1:0] CORDIC_GAIN_Q16 = 50'sd39797;
    localparam logic signed [ZW-1:0] QUARTER_UDEG    = 32'sd90000000;

    typedef struct packed {
        logic [12:0] neutral_speed;
        logic [11:0] cruise_boost;
        logic [12:0] turn_threshold;
        logic [5:0]  steer_gain;
        logic [12:0] speed_min;
        logic [12:0] speed_max;
        logic [15:0] arrive_tol_lat;
        logic [15:0] arrive_tol_lon;
    } cfg_t;

    localparam logic [2:0] REG_NEUTRAL_SPEED  = 3'd0;
    localparam logic [2:0] REG_CRUISE_BOOST   = 3'd1;
    localparam logic [2:0] REG_TURN_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_STEER_GAIN     = 3'd3;
    localparam logic [2:0] REG_SPEED_MIN      = 3'd4;
    localparam logic [2:0] REG_SPEED_MAX      = 3'd5;
    localparam logic [2:0] REG_ARRIVE_TOL_LAT = 3'd6;
    localparam logic [2:0] REG_ARRIVE_TOL_LON = 3'd7;

    function automatic logic signed [ZW-1:0] atan_udeg(input logic [3:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            4'd0:    r = 32'sd45000000;
            4'd1:    r = 32'sd26565051;
            4'd2:    r = 32'sd14036243;
            4'd3:    r = 32'sd7125016;
            4'd4:    r = 32'sd3576334;
            4'd5:    r = 32'sd1789911;
            4'd6:    r = 32'sd895174;
            4'd7:    r = 32'sd447614;
            4'd8:    r = 32'sd223811;
            4'd9:    r = 32'sd111906;
            4'd10:   r = 32'sd55953;
            4'd11:   r = 32'sd27976;
            4'd12:   r = 32'sd13988;
            4'd13:   r = 32'sd6994;
            4'd14:   r = 32'sd3497;
            default: r = 32'sd1749;
        endcase
        return r;
    endfunction

    // n/30 floored at 0, saturated at 255; reciprocal multiply is exact below 7680
    function automatic logic [CMDW-1:0] cmd8(input logic signed [14:0] n);
        logic [28:0] prod;
        logic [CMDW-1:0] r;
        prod = 29'(n[12:0]) * 29'd34953;
        if (n < 0)
            r = '0;
        else if (n >= 15'sd7680)
            r = 8'd255;
        else
            r = prod[27:20];
        return r;
    endfunction

    function automatic logic [SPDW-1:0] clamp_speed(input logic signed [16:0] v,
                                                     input logic [12:0] lo,
                                                     input logic [12:0] hi);
        logic [SPDW-1:0] r;
        if (v > $signed({4'b0, hi}))
            r = hi;
        else if (v < $signed({4'b0, lo}))
            r = lo;
        else
            r = v[12:0];
        return r;
    endfunction

endpackage

// ----- rtl/wsc_cfg.sv -----
module wsc_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wsc_pkg::ADDRW-1:0]  paddr,
    input  logic [wsc_pkg::DATAW-1:0]  pwdata,
    output logic [wsc_pkg::DATAW-1:0]  prdata,
    output logic                       pready,
    output wsc_pkg::cfg_t              cfg
);
    import wsc_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.neutral_speed  <= 13'd4500;
            cfg_reg.cruise_boost   <= 12'd900;
            cfg_reg.turn_threshold <= 13'd400;
            cfg_reg.steer_gain     <= 6'd15;
            cfg_reg.speed_min      <= 13'd3000;
            cfg_reg.speed_max      <= 13'd6000;
            cfg_reg.arrive_tol_lat <= 16'd30;
            cfg_reg.arrive_tol_lon <= 16'd40;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_NEUTRAL_SPEED:  cfg_reg.neutral_speed  <= pwdata[12:0];
                REG_CRUISE_BOOST:   cfg_reg.cruise_boost   <= pwdata[11:0];
                REG_TURN_THRESHOLD: cfg_reg.turn_threshold <= pwdata[12:0];
                REG_STEER_GAIN:     cfg_reg.steer_gain     <= pwdata[5:0];
                REG_SPEED_MIN:      cfg_reg.speed_min      <= pwdata[12:0];
                REG_SPEED_MAX:      cfg_reg.speed_max      <= pwdata[12:0];
                REG_ARRIVE_TOL_LAT: cfg_reg.arrive_tol_lat <= pwdata[15:0];
                REG_ARRIVE_TOL_LON: cfg_reg.arrive_tol_lon <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_NEUTRAL_SPEED:  prdata = {19'b0, cfg_reg.neutral_speed};
            REG_CRUISE_BOOST:   prdata = {20'b0, cfg_reg.cruise_boost};
            REG_TURN_THRESHOLD: prdata = {19'b0, cfg_reg.turn_threshold};
            REG_STEER_GAIN:     prdata = {26'b0, cfg_reg.steer_gain};
            REG_SPEED_MIN:      prdata = {19'b0, cfg_reg.speed_min};
            REG_SPEED_MAX:      prdata = {19'b0, cfg_reg.speed_max};
            REG_ARRIVE_TOL_LAT: prdata = {16'b0, cfg_reg.arrive_tol_lat};
            REG_ARRIVE_TOL_LON: prdata = {16'b0, cfg_reg.arrive_tol_lon};
            default:            prdata = '0;
        endcase
    end

endmodule

// ----- rtl/wsc_store.sv -----
module wsc_store #(
    parameter int DEPTH = wsc_pkg::MAX_WAYPOINTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [AW-1:0]                   waddr,
    input  logic signed [wsc_pkg::LATW-1:0] wlat,
    input  logic signed [wsc_pkg::LONW-1:0] wlon,
    input  logic [AW-1:0]                   raddr,
    output logic signed [wsc_pkg::LATW-1:0] rlat,
    output logic signed [wsc_pkg::LONW-1:0] rlon
);
    import wsc_pkg::*;

    logic [LATW-1:0] lat_mem [DEPTH];
    logic [LONW-1:0] lon_mem [DEPTH];
    logic [LATW-1:0] rlat_reg;
    logic [LONW-1:0] rlon_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            lat_mem[waddr] <= wlat;
            lon_mem[waddr] <= wlon;
        end
        rlat_reg <= lat_mem[raddr];
        rlon_reg <= lon_mem[raddr];
    end

    assign rlat = $signed(rlat_reg);
    assign rlon = $signed(rlon_reg);

endmodule

// ----- rtl/wsc_core.sv -----
module wsc_core #(
    parameter int MAX_WAYPOINTS = wsc_pkg::MAX_WAYPOINTS_DEF,
    parameter int AW            = $clog2(MAX_WAYPOINTS)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wsc_pkg::cfg_t                   cfg,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic signed [wsc_pkg::LATW-1:0] wp_lat,
    input  logic signed [wsc_pkg::LONW-1:0] wp_lon,
    input  logic                            last_waypoint,
    input  logic signed [wsc_pkg::LATW-1:0] cur_lat,
    input  logic signed [wsc_pkg::LONW-1:0] cur_lon,
    input  logic signed [wsc_pkg::HDGW-1:0] heading,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [wsc_pkg::SPDW-1:0]        left_speed,
    output logic [wsc_pkg::SPDW-1:0]        right_speed,
    output logic [wsc_pkg::CMDW-1:0]        common_cmd,
    output logic [wsc_pkg::CMDW-1:0]        diff_cmd,
    output logic [wsc_pkg::IDXW-1:0]        waypoint_index,
    output logic                            steered,
    output logic                            mem_we,
    output logic [AW-1:0]                   mem_waddr,
    output logic [AW-1:0]                   mem_raddr,
    input  logic signed [wsc_pkg::LATW-1:0] mem_rlat,
    input  logic signed [wsc_pkg::LONW-1:0] mem_rlon
);
    import wsc_pkg::*;

    localparam int PW = $clog2(MAX_WAYPOINTS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_PREP  = 4'd2;
    localparam logic [3:0] S_COS   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_PRE   = 4'd5;
    localparam logic [3:0] S_ATAN  = 4'd6;
    localparam logic [3:0] S_DIVI  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_ERR   = 4'd9;
    localparam logic [3:0] S_WRAP  = 4'd10;
    localparam logic [3:0] S_DRIVE = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]              state_reg;
    logic [4:0]              cnt_reg;
    logic signed [CW-1:0]    x_reg, y_reg;
    logic signed [ZW-1:0]    z_reg;
    logic [16:0]             q_reg;
    logic signed [LATW-1:0]  clat_reg;
    logic signed [LONW-1:0]  clon_reg;
    logic signed [HDGW-1:0]  hdg_reg;
    logic signed [28:0]      dlat_reg;
    logic signed [29:0]      dlon_reg;
    logic                    neg_reg, arrive_reg, steered_reg, armed_reg;
    logic signed [19:0]      err_reg;
    logic signed [26:0]      p_reg;
    logic [SPDW-1:0]         left_reg, right_reg;
    logic [IDXW-1:0]         target_reg;
    logic [PW-1:0]           plan_reg, loadpos_reg;
    logic [31:0]             sum_lat_reg, sum_lon_reg, prev_lat_reg, prev_lon_reg;

    logic                    out_valid_reg, out_steered_reg;
    logic [SPDW-1:0]         out_left_reg, out_right_reg;
    logic [CMDW-1:0]         out_common_reg, out_diff_reg;
    logic [IDXW-1:0]         out_index_reg;

    logic accept, room, out_free, store_ok;
    logic [31:0] sum_lat_next, sum_lon_next;
    logic [PW-1:0] loadpos_next;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign store_ok     = (loadpos_reg < PW'(MAX_WAYPOINTS));
    assign sum_lat_next = sum_lat_reg + (store_ok ? 32'(wp_lat) : 32'd0);
    assign sum_lon_next = sum_lon_reg + (store_ok ? 32'(wp_lon) : 32'd0);
    assign loadpos_next = loadpos_reg + (store_ok ? PW'(1) : PW'(0));

    assign mem_we    = accept && !mode && store_ok;
    assign mem_waddr = loadpos_reg[AW-1:0];
    assign mem_raddr = target_reg[AW-1:0];

    // shared CORDIC shifter/adder terms
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] ang;
    assign dx  = y_reg >>> cnt_reg[3:0];
    assign dy  = x_reg >>> cnt_reg[3:0];
    assign ang = atan_udeg(cnt_reg[3:0]);

    // waypoint geometry from the table read
    logic signed [28:0] mid_sum, dlat_w;
    logic signed [29:0] dlon_w;
    logic [27:0]        amag;
    logic [28:0]        dlat_abs;
    logic [29:0]        dlon_abs;
    assign mid_sum  = {mem_rlat[LATW-1], mem_rlat} + {clat_reg[LATW-1], clat_reg};
    assign amag     = mid_sum[28] ? 28'(-mid_sum[28:1]) : mid_sum[28:1];
    assign dlat_w   = {mem_rlat[LATW-1], mem_rlat} - {clat_reg[LATW-1], clat_reg};
    assign dlon_w   = {mem_rlon[LONW-1], mem_rlon} - {clon_reg[LONW-1], clon_reg};
    assign dlat_abs = dlat_w[28] ? 29'(-dlat_w) : dlat_w;
    assign dlon_abs = dlon_w[29] ? 30'(-dlon_w) : dlon_w;

    // cosine clamp and the product that feeds atan2
    logic [16:0]        cmag;
    logic signed [17:0] cval;
    logic signed [47:0] prod_y;
    assign cmag   = x_reg[CW-1] ? 17'd0 :
                    (x_reg > 50'sd65536) ? 17'd65536 : x_reg[16:0];
    assign cval   = neg_reg ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
    assign prod_y = cval * dlon_reg;

    // bearing rounding: shift out 2^6 of the 10^6 divisor, then multiply by 2^45/15625
    localparam logic [31:0] RECIP_15625 = 32'd2251799814;
    logic signed [39:0] nd;
    logic [30:0]        nd_hi;
    logic [62:0]        recip_prod;
    assign nd         = (40'(z_reg) <<< 8) + 40'sd65536500000;
    assign nd_hi      = y_reg[36:6];
    assign recip_prod = 63'(nd_hi) * 63'(RECIP_15625);

    logic signed [17:0] bq0, bq;
    logic signed [19:0] hdg_q8;
    assign bq0    = $signed({1'b0, q_reg}) - 18'sd65536;
    assign bq     = bq0[17] ? bq0 + 18'sd92160 : bq0;
    assign hdg_q8 = {{2{hdg_reg[HDGW-1]}}, hdg_reg, 8'd0};

    // drive terms
    logic signed [26:0] pr, ufull;
    logic signed [15:0] u;
    logic [15:0]        uabs;
    logic [11:0]        boost;
    logic signed [16:0] vl, vr;
    assign pr    = p_reg + (p_reg[26] ? 27'sd255 : 27'sd0);
    assign ufull = pr >>> 8;
    assign u     = ufull[15:0];
    assign uabs  = u[15] ? 16'(-u) : u;
    assign boost = (uabs > {3'b0, cfg.turn_threshold}) ? 12'd0 : cfg.cruise_boost;
    assign vl    = $signed({4'b0, cfg.neutral_speed}) + $signed({5'b0, boost})
                 + {u[15], u};
    assign vr    = $signed({4'b0, cfg.neutral_speed}) + $signed({5'b0, boost})
                 - {u[15], u};

    logic signed [14:0] n_common, n_diff;
    assign n_common = $signed({2'b0, left_reg}) + $signed({2'b0, right_reg}) - 15'sd6000;
    assign n_diff   = $signed({2'b0, left_reg}) - $signed({2'b0, right_reg}) + 15'sd3000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            armed_reg     <= 1'b0;
            steered_reg   <= 1'b0;
            target_reg    <= '0;
            plan_reg      <= '0;
            loadpos_reg   <= '0;
            sum_lat_reg   <= '0;
            sum_lon_reg   <= '0;
            prev_lat_reg  <= '0;
            prev_lon_reg  <= '0;
            left_reg      <= 13'd4500;
            right_reg     <= 13'd4500;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept && !mode)
                    begin
                        if (last_waypoint)
                        begin
                            plan_reg <= loadpos_next;
                            if (sum_lat_next != prev_lat_reg && sum_lon_next != prev_lon_reg)
                                target_reg <= '0;
                            prev_lat_reg <= sum_lat_next;
                            prev_lon_reg <= sum_lon_next;
                            sum_lat_reg  <= '0;
                            sum_lon_reg  <= '0;
                            loadpos_reg  <= '0;
                            armed_reg    <= 1'b1;
                        end
                        else
                        begin
                            sum_lat_reg <= sum_lat_next;
                            sum_lon_reg <= sum_lon_next;
                            loadpos_reg <= loadpos_next;
                        end
                    end
                    else if (accept)
                    begin
                        clat_reg    <= cur_lat;
                        clon_reg    <= cur_lon;
                        hdg_reg     <= heading;
                        steered_reg <= armed_reg;
                        state_reg   <= S_OUT;
                        if (armed_reg)
                        begin
                            armed_reg <= 1'b0;
                            if ({1'b0, target_reg} >= 9'(plan_reg))
                                target_reg <= '0;
                            if (plan_reg != '0)
                                state_reg <= S_READ;
                        end
                    end
                end

                // table read address settles this cycle
                S_READ: state_reg <= S_PREP;

                S_PREP:
                begin
                    dlat_reg   <= dlat_w;
                    dlon_reg   <= dlon_w;
                    arrive_reg <= (dlat_abs <= {13'b0, cfg.arrive_tol_lat}) &&
                                  (dlon_abs <= {14'b0, cfg.arrive_tol_lon});
                    // fold the mid-latitude into the first quadrant
                    if (amag > 28'd90000000)
                    begin
                        z_reg   <= 32'sd180000000 - $signed({4'b0, amag});
                        neg_reg <= 1'b1;
                    end
                    else
                    begin
                        z_reg   <= $signed({4'b0, amag});
                        neg_reg <= 1'b0;
                    end
                    x_reg     <= CORDIC_GAIN_Q16;
                    y_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_COS;
                end

                S_COS:
                begin
                    if (!z_reg[ZW-1])
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - ang;
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + ang;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(CORDIC_STEPS - 1))
                        state_reg <= S_MUL;
                end

                S_MUL:
                begin
                    y_reg     <= {{(CW-48){prod_y[47]}}, prod_y};
                    x_reg     <= {{(CW-45){dlat_reg[28]}}, dlat_reg, 16'd0};
                    state_reg <= S_PRE;
                end

                S_PRE:
                begin
                    cnt_reg   <= '0;
                    z_reg     <= '0;
                    state_reg <= S_ATAN;
                    if (x_reg == '0 && y_reg == '0)
                        state_reg <= S_DIVI;
                    else if (x_reg[CW-1])
                    begin
                        // rotate into the right half plane
                        if (!y_reg[CW-1])
                        begin
                            x_reg <= y_reg;
                            y_reg <= -x_reg;
                            z_reg <= QUARTER_UDEG;
                        end
                        else
                        begin
                            x_reg <= -y_reg;
                            y_reg <= x_reg;
                            z_reg <= -QUARTER_UDEG;
                        end
                    end
                end

                S_ATAN:
                begin
                    if (!y_reg[CW-1])
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + ang;
                    end
                    else
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - ang;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(CORDIC_STEPS - 1))
                        state_reg <= S_DIVI;
                end

                S_DIVI:
                begin
                    // bias keeps the dividend positive for the floor
                    y_reg     <= {{(CW-40){nd[39]}}, nd};
                    state_reg <= S_DIV;
                end

                S_DIV:
                begin
                    q_reg     <= recip_prod[61:45];
                    state_reg <= S_ERR;
                end

                S_ERR:
                begin
                    err_reg   <= {{2{bq[17]}}, bq} - hdg_q8;
                    state_reg <= S_WRAP;
                end

                S_WRAP:
                begin
                    if (err_reg < -20'sd46080)
                        err_reg <= err_reg + 20'sd92160;
                    else if (err_reg > 20'sd46080)
                        err_reg <= err_reg - 20'sd92160;
                    else
                    begin
                        p_reg     <= $signed({1'b0, cfg.steer_gain}) * err_reg;
                        state_reg <= S_DRIVE;
                    end
                end

                S_DRIVE:
                begin
                    left_reg  <= clamp_speed(vl, cfg.speed_min, cfg.speed_max);
                    right_reg <= clamp_speed(vr, cfg.speed_min, cfg.speed_max);
                    if (arrive_reg)
                        target_reg <= target_reg + 8'd1;
                    state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            out_left_reg    <= left_reg;
            out_right_reg   <= right_reg;
            out_common_reg  <= cmd8(n_common);
            out_diff_reg    <= cmd8(n_diff);
            out_index_reg   <= target_reg;
            out_steered_reg <= steered_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign left_speed     = out_left_reg;
    assign right_speed    = out_right_reg;
    assign common_cmd     = out_common_reg;
    assign diff_cmd       = out_diff_reg;
    assign waypoint_index = out_index_reg;
    assign steered        = out_steered_reg;

endmodule

// ----- rtl/waypoint_steering_controller.sv -----
// Load words: accepted with no result; the next word can be taken the cycle after.
// Tick without an armed step: result word registered once the output is free.
// Steered tick: the result word is set by two 16-step CORDIC passes on one shared
//   shift/add unit (no second pass for a zero vector) and up to two heading wraps.
//   A stalled result word holds the next result and the input side until it moves on.
// Reset (rst_n, async low): config to defaults, empty plan, thrusters at 4500.
module waypoint_steering_controller #(
    parameter int MAX_WAYPOINTS = wsc_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wsc_pkg::ADDRW-1:0]       paddr,
    input  logic [wsc_pkg::DATAW-1:0]       pwdata,
    output logic [wsc_pkg::DATAW-1:0]       prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic signed [wsc_pkg::LATW-1:0] wp_lat,
    input  logic signed [wsc_pkg::LONW-1:0] wp_lon,
    input  logic                            last_waypoint,
    input  logic signed [wsc_pkg::LATW-1:0] cur_lat,
    input  logic signed [wsc_pkg::LONW-1:0] cur_lon,
    input  logic signed [wsc_pkg::HDGW-1:0] heading,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [wsc_pkg::SPDW-1:0]        left_speed,
    output logic [wsc_pkg::SPDW-1:0]        right_speed,
    output logic [wsc_pkg::CMDW-1:0]        common_cmd,
    output logic [wsc_pkg::CMDW-1:0]        diff_cmd,
    output logic [wsc_pkg::IDXW-1:0]        waypoint_index,
    output logic                            steered
);
    import wsc_pkg::*;

    localparam int AW = $clog2(MAX_WAYPOINTS);

    cfg_t                   cfg;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic signed [LATW-1:0] mem_rlat;
    logic signed [LONW-1:0] mem_rlon;

    wsc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wsc_store #(.DEPTH(MAX_WAYPOINTS), .AW(AW)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wlat  (wp_lat),
        .wlon  (wp_lon),
        .raddr (mem_raddr),
        .rlat  (mem_rlat),
        .rlon  (mem_rlon)
    );

    wsc_core #(.MAX_WAYPOINTS(MAX_WAYPOINTS), .AW(AW)) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .wp_lat         (wp_lat),
        .wp_lon         (wp_lon),
        .last_waypoint  (last_waypoint),
        .cur_lat        (cur_lat),
        .cur_lon        (cur_lon),
        .heading        (heading),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .left_speed     (left_speed),
        .right_speed    (right_speed),
        .common_cmd     (common_cmd),
        .diff_cmd       (diff_cmd),
        .waypoint_index (waypoint_index),
        .steered        (steered),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_raddr      (mem_raddr),
        .mem_rlat       (mem_rlat),
        .mem_rlon       (mem_rlon)
    );

endmodule

// ----- rtl/wsc_checker.sv -----
module wsc_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     mode,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [wsc_pkg::SPDW-1:0] left_speed,
    input logic [wsc_pkg::SPDW-1:0] right_speed,
    input logic [wsc_pkg::CMDW-1:0] common_cmd
);

    // hold a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // a load word leaves the input side free in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !mode |=> !in_stall)
        else $error("load word held the input side");

    // a tick always occupies the sequencer for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode |=> in_stall)
        else $error("tick accepted without going busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (({1'b0, left_speed} + {1'b0, right_speed}) < 14'd6000)
        |-> common_cmd == 8'd0)
        else $error("common command not floored");

endmodule

bind waypoint_steering_controller wsc_checker u_wsc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .left_speed  (left_speed),
    .right_speed (right_speed),
    .common_cmd  (common_cmd)
);

// ----- dv/tb_waypoint_steering_controller.sv -----
module tb_waypoint_steering_controller;
    import wsc_pkg::*;

    localparam bit MODE_LOAD = 1'b0;
    localparam bit MODE_TICK = 1'b1;
    localparam longint UDEG = 1000000;
    localparam longint ATAN_UDEG [16] = '{45000000, 26565051, 14036243, 7125016,
        3576334, 1789911, 895174, 447614, 223811, 111906, 55953, 27976, 13988,
        6994, 3497, 1749};

    typedef struct packed {
        logic [SPDW-1:0] left;
        logic [SPDW-1:0] right;
        logic [CMDW-1:0] common;
        logic [CMDW-1:0] diff;
        logic [IDXW-1:0] idx;
        logic            steer;
    } thrust_t;

    typedef struct {
        bit      m;
        longint  wlat;
        longint  wlon;
        bit      last;
        longint  clat;
        longint  clon;
        longint  hdg;
        bit      typed;
        thrust_t res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDRW-1:0] paddr = '0;
    logic [DATAW-1:0] pwdata = '0;
    logic [DATAW-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic mode = 1'b0;
    logic signed [LATW-1:0] wp_lat = '0;
    logic signed [LONW-1:0] wp_lon = '0;
    logic last_waypoint = 1'b0;
    logic signed [LATW-1:0] cur_lat = '0;
    logic signed [LONW-1:0] cur_lon = '0;
    logic signed [HDGW-1:0] heading = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [SPDW-1:0] left_speed, right_speed;
    logic [CMDW-1:0] common_cmd, diff_cmd;
    logic [IDXW-1:0] waypoint_index;
    logic steered;

    waypoint_steering_controller dut (.*);

    always #1 clk = ~clk;

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // predictor state
    cfg_t    cfg;
    longint  lat_tab [256];
    longint  lon_tab [256];
    int      plan_cnt, load_pos, tgt_idx;
    bit [31:0] lat_acc, lon_acc, lat_prev, lon_prev;
    bit      armed;
    longint  left_cmd, right_cmd;

    thrust_t thrust_q [$];
    int      errors = 0;
    bit      idle_on = 1'b1;
    bit      hold_req = 1'b0;

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if (n % d != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic longint cos_q16(longint a);
        longint x, y, z, dx, dy;
        bit neg;
        x = 39797;
        y = 0;
        neg = 1'b0;
        if (a < 0)
            a = -a;
        a = a % (360 * UDEG);
        if (a > 180 * UDEG)
            a = 360 * UDEG - a;
        if (a > 90 * UDEG)
        begin
            a = 180 * UDEG - a;
            neg = 1'b1;
        end
        z = a;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ATAN_UDEG[i];
            end
            else
            begin
                x += dx; y -= dy; z += ATAN_UDEG[i];
            end
        end
        if (x < 0)
            x = 0;
        if (x > 65536)
            x = 65536;
        return neg ? -x : x;
    endfunction

    function automatic longint bearing_udeg(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 90 * UDEG;
            end
            else
            begin
                x = -y; y = t; z = -90 * UDEG;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += ATAN_UDEG[i];
            end
            else
            begin
                x -= dx; y += dy; z -= ATAN_UDEG[i];
            end
        end
        return z;
    endfunction

    function automatic longint clamp_cmd(longint v);
        if (v > longint'(cfg.speed_max))
            return longint'(cfg.speed_max);
        if (v < longint'(cfg.speed_min))
            return longint'(cfg.speed_min);
        return v;
    endfunction

    function automatic logic [7:0] scale_cmd(longint n);
        if (n < 0)
            return 8'd0;
        return (n / 30 > 255) ? 8'd255 : 8'(n / 30);
    endfunction

    function automatic void steer_step(longint clat, longint clon, longint hdg);
        longint wlat, wlon, c, z, bq, err, u, boost, dl, dn;
        if (tgt_idx >= plan_cnt)
            tgt_idx = 0;
        if (plan_cnt == 0)
            return;
        wlat = lat_tab[tgt_idx];
        wlon = lon_tab[tgt_idx];
        dl = wlat - clat;
        dn = wlon - clon;
        c = cos_q16((clat + wlat) >>> 1);
        z = bearing_udeg(c * dn, dl * 65536);
        bq = floor_div(z * 256 + UDEG / 2, UDEG);
        if (bq < 0)
            bq += 360 * 256;
        err = bq - hdg * 256;
        while (err < -180 * 256)
            err += 360 * 256;
        while (err > 180 * 256)
            err -= 360 * 256;
        u = (longint'(cfg.steer_gain) * err) / 256;
        boost = ((u < 0 ? -u : u) > longint'(cfg.turn_threshold)) ? 0
                : longint'(cfg.cruise_boost);
        left_cmd = clamp_cmd(longint'(cfg.neutral_speed) + boost + u);
        right_cmd = clamp_cmd(longint'(cfg.neutral_speed) + boost - u);
        dl = clat - wlat;
        dn = clon - wlon;
        if ((dl < 0 ? -dl : dl) <= longint'(cfg.arrive_tol_lat) &&
            (dn < 0 ? -dn : dn) <= longint'(cfg.arrive_tol_lon))
            tgt_idx = (tgt_idx + 1) & 8'hFF;
    endfunction

    // advance the predictor by one accepted word; returns 1 if a result is due
    function automatic bit predict_thrust(row_t w, output thrust_t r);
        bit st;
        st = 1'b0;
        r = '0;
        if (w.m == MODE_LOAD)
        begin
            if (load_pos < 256)
            begin
                lat_tab[load_pos] = w.wlat;
                lon_tab[load_pos] = w.wlon;
                lat_acc += 32'(w.wlat);
                lon_acc += 32'(w.wlon);
                load_pos++;
            end
            if (w.last)
            begin
                plan_cnt = load_pos;
                if (lat_acc != lat_prev && lon_acc != lon_prev)
                    tgt_idx = 0;
                lat_prev = lat_acc;
                lon_prev = lon_acc;
                lat_acc = 0;
                lon_acc = 0;
                load_pos = 0;
                armed = 1'b1;
            end
            return 1'b0;
        end
        if (armed)
        begin
            armed = 1'b0;
            steer_step(w.clat, w.clon, w.hdg);
            st = 1'b1;
        end
        r.left = 13'(left_cmd);
        r.right = 13'(right_cmd);
        r.common = scale_cmd(left_cmd + right_cmd - 6000);
        r.diff = scale_cmd(left_cmd - right_cmd + 3000);
        r.idx = 8'(tgt_idx);
        r.steer = st;
        return 1'b1;
    endfunction

    task automatic apb_write(logic [2:0] idx, int unsigned val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDRW'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_NEUTRAL_SPEED:  cfg.neutral_speed = 13'(val);
            REG_CRUISE_BOOST:   cfg.cruise_boost = 12'(val);
            REG_TURN_THRESHOLD: cfg.turn_threshold = 13'(val);
            REG_STEER_GAIN:     cfg.steer_gain = 6'(val);
            REG_SPEED_MIN:      cfg.speed_min = 13'(val);
            REG_SPEED_MAX:      cfg.speed_max = 13'(val);
            REG_ARRIVE_TOL_LAT: cfg.arrive_tol_lat = 16'(val);
            REG_ARRIVE_TOL_LON: cfg.arrive_tol_lon = 16'(val);
            default:            ;
        endcase
    endtask

    task automatic send_word(row_t w);
        int gap;
        thrust_t r;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= w.m;
        wp_lat <= w.wlat[LATW-1:0];
        wp_lon <= w.wlon[LONW-1:0];
        last_waypoint <= w.last;
        cur_lat <= w.clat[LATW-1:0];
        cur_lon <= w.clon[LONW-1:0];
        heading <= w.hdg[HDGW-1:0];
        do
            @(posedge clk);
        while (in_stall);
        if (predict_thrust(w, r))
            thrust_q = {thrust_q, (w.typed ? w.res : r)};
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (thrust_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic longint rnd_lat();
        return longint'($urandom_range(0, 180000000)) - 90000000;
    endfunction

    function automatic longint rnd_lon();
        return longint'($urandom_range(0, 360000000)) - 180000000;
    endfunction

    function automatic longint near(longint v, longint lim);
        v += longint'($urandom_range(0, 60)) - 30;
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v;
    endfunction

    function automatic row_t load_row(longint a, longint b, bit l);
        row_t w;
        w = '{MODE_LOAD, a, b, l, rnd_lat(), rnd_lon(), 0, 1'b0, '0};
        w.hdg = longint'($urandom_range(0, 720)) - 360;
        return w;
    endfunction

    function automatic row_t tick_row();
        row_t w;
        int t;
        w = '{MODE_TICK, rnd_lat(), rnd_lon(), $urandom_range(0, 1), rnd_lat(),
              rnd_lon(), longint'($urandom_range(0, 720)) - 360, 1'b0, '0};
        t = (tgt_idx < plan_cnt) ? tgt_idx : 0;
        // aim close to the target so arrivals happen
        if (plan_cnt > 0 && $urandom_range(0, 1))
        begin
            w.clat = $urandom_range(0, 1) ? lat_tab[t] : near(lat_tab[t], 90000000);
            w.clon = $urandom_range(0, 1) ? lon_tab[t] : near(lon_tab[t], 180000000);
        end
        return w;
    endfunction

    task automatic send_plan(int n);
        longint a [$];
        longint b [$];
        for (int i = 0; i < n; i++)
        begin
            a = {a, rnd_lat()};
            b = {b, rnd_lon()};
        end
        // repeat the plan now and then so the sums match and the index is kept
        if ($urandom_range(0, 4) == 0 && plan_cnt > 0 && plan_cnt < 8)
        begin
            a.delete();
            b.delete();
            for (int i = 0; i < plan_cnt; i++)
            begin
                a = {a, lat_tab[i]};
                b = {b, lon_tab[i]};
            end
        end
        foreach (a[i])
            send_word(load_row(a[i], b[i], i == a.size() - 1));
    endtask

    task automatic random_words(int cnt);
        int sent;
        int k;
        sent = 0;
        while (sent < cnt)
        begin
            k = $urandom_range(0, 9);
            if (k < 7)
            begin
                k = $urandom_range(1, 6);
                send_plan(k);
                sent += k;
                k = $urandom_range(1, 4);
                repeat (k) send_word(tick_row());
                sent += k;
            end
            else if (k < 8)
            begin
                send_word(load_row(rnd_lat(), rnd_lon(), 1'b0));
                sent++;
            end
            else
            begin
                send_word(tick_row());
                sent++;
            end
        end
    endtask

    task automatic check_thrust(thrust_t e);
        if (left_speed !== e.left)
        begin
            $error("left_speed exp %0d got %0d", e.left, left_speed);
            errors++;
        end
        if (right_speed !== e.right)
        begin
            $error("right_speed exp %0d got %0d", e.right, right_speed);
            errors++;
        end
        if (common_cmd !== e.common)
        begin
            $error("common_cmd exp %0d got %0d", e.common, common_cmd);
            errors++;
        end
        if (diff_cmd !== e.diff)
        begin
            $error("diff_cmd exp %0d got %0d", e.diff, diff_cmd);
            errors++;
        end
        if (waypoint_index !== e.idx)
        begin
            $error("waypoint_index exp %0d got %0d", e.idx, waypoint_index);
            errors++;
        end
        if (steered !== e.steer)
        begin
            $error("steered exp %0d got %0d", e.steer, steered);
            errors++;
        end
    endtask

    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = idle_on ? $urandom_range(0, 7) : 0;
            if (hold_req)
            begin
                hold_req = 1'b0;
                n = 300;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
            if (thrust_q.size() == 0)
            begin
                $error("result word with none expected");
                errors++;
            end
            else
                check_thrust(thrust_q.pop_front());
        end
    end

    initial
    begin
        row_t dir_rows [$];
        int unsigned vals [8];
        cfg = '{13'd4500, 12'd900, 13'd400, 6'd15, 13'd3000, 13'd6000, 16'd30, 16'd40};
        foreach (lat_tab[i])
        begin
            lat_tab[i] = 0;
            lon_tab[i] = 0;
        end
        plan_cnt = 0; load_pos = 0; tgt_idx = 0;
        lat_acc = 0; lon_acc = 0; lat_prev = 0; lon_prev = 0;
        armed = 1'b0;
        left_cmd = 4500;
        right_cmd = 4500;

        dir_rows = '{
            '{MODE_TICK, 0, 0, 0, 0, 0, 0, 1'b1, '{13'd4500, 13'd4500, 8'd100, 8'd100, 8'd0, 1'b0}},
            '{MODE_LOAD, 90000000, 180000000, 0, 0, 0, 0, 1'b0, '0},
            '{MODE_LOAD, -90000000, -180000000, 1, 0, 0, 0, 1'b0, '0},
            '{MODE_TICK, 0, 0, 0, -90000000, -180000000, 360, 1'b0, '0},
            '{MODE_TICK, 0, 0, 0, 90000000, 180000000, -360, 1'b0, '0},
            '{MODE_LOAD, 0, 0, 1, 0, 0, 0, 1'b0, '0},
            '{MODE_TICK, 0, 0, 0, 0, 0, -360, 1'b0, '0},
            '{MODE_LOAD, 1000, -2000, 1, 0, 0, 0, 1'b0, '0},
            '{MODE_TICK, 0, 0, 0, 970, -1960, 0, 1'b0, '0},
            '{MODE_LOAD, 1000, -2000, 1, 0, 0, 0, 1'b0, '0},
            '{MODE_TICK, 0, 0, 0, 969, -1960, 1, 1'b0, '0},
            '{MODE_LOAD, 45000000, 0, 0, 0, 0, 0, 1'b0, '0},
            '{MODE_LOAD, -45000000, 100, 1, 0, 0, 0, 1'b0, '0},
            '{MODE_TICK, 0, 0, 0, 89999999, -179999999, 179, 1'b0, '0},
            '{MODE_LOAD, 5, 5, 1, 0, 0, 0, 1'b0, '0},
            '{MODE_TICK, 0, 0, 0, 5, 100000, -181, 1'b0, '0},
            '{MODE_LOAD, -80000000, 170000000, 1, 0, 0, 0, 1'b0, '0},
            '{MODE_TICK, 0, 0, 0, 80000000, -170000000, -1, 1'b0, '0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i]);
        random_words(25);
        drain();

        for (int p = 1; p <= 5; p++)
        begin
            case (p)
                1: vals = '{0, 0, 0, 0, 0, 0, 0, 0};
                2: vals = '{8191, 4095, 8191, 63, 8191, 8191, 65535, 65535};
                3: vals = '{4500, 4095, 100, 63, 5000, 2000, 0, 65535};
                4: vals = '{4500, 900, 8191, 1, 0, 8191, 2000, 3000};
                default:
                    foreach (vals[j])
                        vals[j] = $urandom();
            endcase
            for (int j = 0; j < 8; j++)
                apb_write(3'(j), vals[j]);
            idle_on = (p != 2);
            if (p == 1)
                hold_req = 1'b1;
            random_words(p == 3 ? 15 : 25);
            // overflow the table once
            if (p == 4)
            begin
                for (int j = 0; j < 259; j++)
                    send_word(load_row(rnd_lat(), rnd_lon(), j == 258));
                repeat (6) send_word(tick_row());
            end
            drain();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
